// ===== src/tmc_pkg.sv =====
// torch mode controller package: shared constants, register indexes, state and config types
// and the mode wrap and sos pattern functions. no dependencies.

package tmc_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_FUNC_COUNT   = 2'd0;
  localparam logic [1:0] REG_LED_COUNT    = 2'd1;
  localparam logic [1:0] REG_HOLD_TIMEOUT = 2'd2;

  localparam logic [2:0]  FUNC_COUNT_RESET   = 3'd5;
  localparam logic [1:0]  LED_COUNT_RESET    = 2'd3;
  localparam logic [15:0] HOLD_TIMEOUT_RESET = 16'd3000;

  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_FULL   = 3'd1;
  localparam logic [2:0] MODE_DIM    = 3'd2;
  localparam logic [2:0] MODE_DIMMER = 3'd3;
  localparam logic [2:0] MODE_STROBE = 3'd4;
  localparam logic [2:0] MODE_SOS    = 3'd5;
  localparam logic [3:0] MODE_LIMIT  = 4'd6;

  localparam logic       KIND_TICK = 1'b0;
  localparam logic       KIND_JUMP = 1'b1;

  localparam logic [7:0]  SLOT_MS        = 8'd200;
  localparam logic [7:0]  STROBE_HALF_MS = 8'd100;
  localparam logic [4:0]  SOS_SLOTS      = 5'd22;
  localparam logic [7:0]  FULL_LEVEL     = 8'd255;
  localparam logic [7:0]  DIM_LEVEL      = 8'd180;
  localparam logic [7:0]  DIMMER_LEVEL   = 8'd120;
  localparam logic [15:0] HOLD_MAX       = 16'hffff;

  typedef struct packed {
    logic [2:0]  func_count;
    logic [1:0]  led_count;
    logic [15:0] hold_timeout;
  } tmc_cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        button_prev;
    logic [15:0] hold_ms;
    logic [7:0]  ms_in_slot;
    logic [4:0]  sos_slot;
  } tmc_state_t;

  // anything at or past six, or above the configured count, falls back to off
  function automatic logic [2:0] wrap_mode(input logic [3:0] m, input logic [2:0] fc);
    logic [2:0] r;
    if (m >= MODE_LIMIT || m > {1'b0, fc}) begin
      r = MODE_OFF;
    end else begin
      r = m[2:0];
    end
    return r;
  endfunction

  function automatic logic sos_on(input logic [4:0] s);
    logic r;
    r = (s == 5'd0) || (s == 5'd2) || (s == 5'd4) ||
        (s >= 5'd8 && s <= 5'd10) || (s >= 5'd12 && s <= 5'd14) ||
        (s >= 5'd16 && s <= 5'd18);
    return r;
  endfunction

endpackage

// ===== src/tmc_if.sv =====
// valid/ready channel interfaces for the torch mode controller: command in, result out
// depends on nothing

interface tmc_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       button_level;
  logic [2:0] mode_request;

  modport source (output valid, kind, button_level, mode_request, input ready);
  modport sink (input valid, kind, button_level, mode_request, output ready);
endinterface

interface tmc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] led1_level;
  logic [7:0] led2_level;
  logic [7:0] led3_level;
  logic [2:0] mode;

  modport source (output valid, led1_level, led2_level, led3_level, mode, input ready);
  modport sink (input valid, led1_level, led2_level, led3_level, mode, output ready);
endinterface

// ===== src/tmc_regs.sv =====
// apb configuration registers: function count, led count and hold timeout
// depends on tmc_pkg

module tmc_regs
  import tmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output tmc_cfg_t              cfg
);

  tmc_cfg_t   regs;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.func_count   <= FUNC_COUNT_RESET;
      regs.led_count    <= LED_COUNT_RESET;
      regs.hold_timeout <= HOLD_TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FUNC_COUNT:   regs.func_count   <= pwdata[2:0];
        REG_LED_COUNT:    regs.led_count    <= pwdata[1:0];
        REG_HOLD_TIMEOUT: regs.hold_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FUNC_COUNT:   prdata = {29'd0, regs.func_count};
      REG_LED_COUNT:    prdata = {30'd0, regs.led_count};
      REG_HOLD_TIMEOUT: prdata = {16'd0, regs.hold_timeout};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== src/tmc_core.sv =====
// mode state: slot timers, button edge detect, hold timer and mode advance
// depends on tmc_pkg

module tmc_core
  import tmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       kind,
  input  logic       button_level,
  input  logic [2:0] mode_request,
  input  tmc_cfg_t   cfg,
  output tmc_state_t state_next
);

  tmc_state_t state;
  logic [7:0]  ms_inc;
  logic [15:0] hold_inc;

  always_comb begin
    state_next = state;
    ms_inc     = state.ms_in_slot + 8'd1;
    hold_inc   = state.hold_ms;
    if (kind == KIND_JUMP) begin
      state_next.mode = wrap_mode({1'b0, mode_request}, cfg.func_count);
    end else begin
      if (ms_inc >= SLOT_MS) begin
        state_next.ms_in_slot = '0;
        state_next.sos_slot   = (state.sos_slot + 5'd1 >= SOS_SLOTS) ? '0 :
                                state.sos_slot + 5'd1;
      end else begin
        state_next.ms_in_slot = ms_inc;
      end
      // hold timer saturates rather than wrapping
      if (state.button_prev && state.hold_ms != HOLD_MAX) begin
        hold_inc = state.hold_ms + 16'd1;
      end
      state_next.hold_ms = hold_inc;
      if (button_level && !state.button_prev) begin
        state_next.hold_ms     = '0;
        state_next.button_prev = 1'b1;
      end else if (!button_level && state.button_prev) begin
        state_next.mode        = wrap_mode({1'b0, state.mode} + 4'd1, cfg.func_count);
        state_next.button_prev = 1'b0;
      end else if (state.button_prev && hold_inc > cfg.hold_timeout) begin
        state_next.mode = MODE_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule

// ===== src/tmc_led_map.sv =====
// per-mode led level mapping from the updated state and the fitted led count
// depends on tmc_pkg

module tmc_led_map
  import tmc_pkg::*;
(
  input  tmc_state_t st,
  input  logic [1:0] led_count,
  output logic [7:0] led1,
  output logic [7:0] led2,
  output logic [7:0] led3
);

  logic [1:0] leds;

  // zero leds behaves as one
  assign leds = (led_count == 2'd0) ? 2'd1 : led_count;

  always_comb begin
    led1 = '0;
    led2 = '0;
    led3 = '0;
    case (st.mode)
      MODE_FULL: led1 = FULL_LEVEL;
      MODE_DIM: begin
        if (leds == 2'd3) led2 = FULL_LEVEL;
        else              led1 = DIM_LEVEL;
      end
      MODE_DIMMER: begin
        if (leds == 2'd1)      led1 = DIMMER_LEVEL;
        else if (leds == 2'd2) led2 = FULL_LEVEL;
        else                   led3 = FULL_LEVEL;
      end
      MODE_STROBE: begin
        if (st.ms_in_slot >= STROBE_HALF_MS) led1 = FULL_LEVEL;
      end
      MODE_SOS: begin
        if (sos_on(st.sos_slot)) led1 = FULL_LEVEL;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/torch_mode_controller.sv =====
// torch mode controller top level: apb registers, mode state, led mapping and result register
// depends on tmc_pkg, tmc_if, tmc_regs, tmc_core and tmc_led_map
//
// usage
//   cmd carries one transaction per millisecond tick (kind 0, button_level sampled)
//   or a jump to mode_request (kind 1). every command transaction gives exactly one
//   result transaction with the three led pwm levels and the current mode.
//   the apb port sets function count, led count and hold timeout; write it only while
//   no result is pending.
// result timing and throughput
//   the result is registered and valid in the cycle after the command is taken. one
//   command per cycle is accepted while result.ready is high (single result register).
// reset
//   rst (synchronous) returns to mode off, button released, timers at zero and the
//   registers to function count 5, led count 3, hold timeout 3000. no result is pending.
// stalls
//   while result.ready is low with a result held, cmd.ready drops; a new command is
//   taken in the same cycle that the held result leaves.

module torch_mode_controller
  import tmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tmc_cmd_if.sink               cmd,
  tmc_res_if.source             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  tmc_cfg_t   cfg;
  tmc_state_t state_next;
  logic       take;
  logic       res_valid;
  logic [7:0] led1;
  logic [7:0] led2;
  logic [7:0] led3;
  logic [7:0] led1_q;
  logic [7:0] led2_q;
  logic [7:0] led3_q;
  logic [2:0] mode_q;

  assign cmd.ready = !res_valid || result.ready;
  assign take      = cmd.valid && cmd.ready;

  tmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .kind         (cmd.kind),
    .button_level (cmd.button_level),
    .mode_request (cmd.mode_request),
    .cfg          (cfg),
    .state_next   (state_next)
  );

  tmc_led_map u_led_map (
    .st        (state_next),
    .led_count (cfg.led_count),
    .led1      (led1),
    .led2      (led2),
    .led3      (led3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      led1_q <= led1;
      led2_q <= led2;
      led3_q <= led3;
      mode_q <= state_next.mode;
    end
  end

  assign result.valid      = res_valid;
  assign result.led1_level = led1_q;
  assign result.led2_level = led2_q;
  assign result.led3_level = led3_q;
  assign result.mode       = mode_q;

endmodule
